// ----- rtl/core/fsfe_pkg.sv -----
// Shared types, widths, constants, rounding, clamp and node-index helpers of the 2D shape function evaluator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fsfe_pkg;

   // Fraction bits of coordinates and results
   localparam int FRAC_BITS = 16;

   // Fixed field widths
   localparam int COORD_W = 18;
   localparam int OUT_W   = 22;
   localparam int NODES   = 8;
   localparam int NFIELDS = 6;
   localparam int NMUL    = 10;

   // Internal widths, sized for any coordinate bit pattern
   localparam int MAG_W = (FRAC_BITS > COORD_W - 1) ? FRAC_BITS : COORD_W - 1;
   localparam int OW    = MAG_W + 5;
   localparam int PW    = 2 * OW;
   localparam int AH    = (FRAC_BITS > 2 * COORD_W - 2 - FRAC_BITS) ?
                          FRAC_BITS : 2 * COORD_W - 2 - FRAC_BITS;
   localparam int AW    = AH + 3;
   localparam int QW    = AW + OW;
   localparam int VA    = PW - FRAC_BITS;
   localparam int VB    = QW - FRAC_BITS;
   localparam int VW    = ((VA > VB) ? VA : VB) + 2;

   // Result field positions
   localparam int FLD_H  = 0;
   localparam int FLD_R  = 1;
   localparam int FLD_S  = 2;
   localparam int FLD_RR = 3;
   localparam int FLD_RS = 4;
   localparam int FLD_SS = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OUT_W-1:0]   out_type;
   typedef logic [2:0]                node_type;
   typedef logic signed [OW-1:0]      op_type;
   typedef logic signed [PW-1:0]      prod_type;
   typedef logic signed [AW-1:0]      a_type;
   typedef logic signed [QW-1:0]      qprod_type;
   typedef logic signed [VW-1:0]      val_type;

   typedef enum logic [1:0] {
      KIND_TRI3  = 2'd0,
      KIND_TRI6  = 2'd1,
      KIND_QUAD4 = 2'd2,
      KIND_QUAD8 = 2'd3
   } kind_type;

   // Fixed-point constants
   localparam op_type  ONE_OP    = op_type'(1) <<< FRAC_BITS;
   localparam a_type   ONE_A     = a_type'(1) <<< FRAC_BITS;
   localparam val_type ONE_V     = val_type'(1) <<< FRAC_BITS;
   localparam val_type QUARTER_V = val_type'(1) <<< (FRAC_BITS - 2);
   localparam val_type FOUR_V    = val_type'(1) <<< (FRAC_BITS + 2);
   localparam val_type EIGHT_V   = val_type'(1) <<< (FRAC_BITS + 3);
   localparam val_type OUT_MAX_V = (val_type'(1) <<< (OUT_W - 1)) - val_type'(1);
   localparam val_type OUT_MIN_V = -(val_type'(1) <<< (OUT_W - 1));

   // Linear terms carried down the pipeline
   typedef struct packed {
      op_type t;
      op_type r;
      op_type s;
      op_type rm;
      op_type rp;
      op_type sm;
      op_type sp;
   } lin_type;

   // One coordinate beat entering the pipeline
   typedef struct packed {
      logic      valid;
      coord_type r;
      coord_type s;
      kind_type  kind;
   } issue_type;

   // Saturated results of one item, with a one-cycle load flag
   typedef struct packed {
      logic                                 load;
      kind_type                             kind;
      out_type [NODES-1:0][NFIELDS-1:0]     fld;
   } bank_type;

   // Round half up to k fewer fraction bits
   function automatic val_type round_prod(prod_type x, int k);
      prod_type w;
      w = (x + (prod_type'(1) <<< (k - 1))) >>> k;
      return w[VW-1:0];
   endfunction

   function automatic val_type round_q(qprod_type x, int k);
      qprod_type w;
      w = (x + (qprod_type'(1) <<< (k - 1))) >>> k;
      return w[VW-1:0];
   endfunction

   function automatic val_type round_v(val_type x, int k);
      val_type w;
      w = (x + (val_type'(1) <<< (k - 1))) >>> k;
      return w;
   endfunction

   // Clamp to the result range
   function automatic out_type sat_out(val_type v);
      val_type w;
      w = v;
      if (w > OUT_MAX_V) begin
         w = OUT_MAX_V;
      end else if (w < OUT_MIN_V) begin
         w = OUT_MIN_V;
      end
      return w[OUT_W-1:0];
   endfunction

   // Index of the final node of an element kind
   function automatic node_type last_index(kind_type kind);
      node_type idx;
      unique case (kind)
         KIND_TRI3:  idx = 3'd2;
         KIND_TRI6:  idx = 3'd5;
         KIND_QUAD4: idx = 3'd3;
         KIND_QUAD8: idx = 3'd7;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fsfe_pipe.sv -----
// Seven-stage arithmetic pipeline: all node values and derivatives of one coordinate pair.
// Depends on fsfe_pkg; feeds the result bank read by the top level.
`default_nettype none

module fsfe_pipe
   import fsfe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire issue_type issue,
   output bank_type       bank
);

   // Valid bits of the stages
   logic s0_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, load_ff;

   // Stage 0: captured coordinates
   coord_type s0_r_ff, s0_s_ff;
   kind_type  s0_kind_ff;

   // Stage 1: linear terms and multiplier operands
   lin_type  lin_in, lin1_ff;
   op_type   ma_in [NMUL];
   op_type   mb_in [NMUL];
   op_type   ma_ff [NMUL];
   op_type   mb_ff [NMUL];
   op_type   r_w, s_w;
   kind_type s1_kind_ff;

   // Stage 2: products
   prod_type p_ff [NMUL];
   lin_type  lin2_ff;
   kind_type s2_kind_ff;

   // Stage 3: rounded products
   val_type  nv_in [6];
   val_type  nv_ff [6];
   val_type  x_in [4];
   val_type  x_ff [4];
   val_type  ta, tb;
   a_type    a_in, b_in, a_ff, b_ff;
   lin_type  lin3_ff;
   kind_type s3_kind_ff;
   logic     quad;

   // Stage 4: edge node products
   qprod_type q_ff [4];
   val_type   nv4_ff [6];
   val_type   x4_ff [4];
   a_type     a4_ff, b4_ff;
   lin_type   lin4_ff;
   kind_type  s4_kind_ff;

   // Stage 5: assembled raw fields
   val_type  asm_in [NODES][NFIELDS];
   val_type  s5_fld_ff [NODES][NFIELDS];
   val_type  rv, sv, tv, rmv, rpv, smv, spv, av, bv;
   kind_type s5_kind_ff;

   // Stage 6: corner correction and clamp
   val_type  fix [NODES][NFIELDS];
   out_type  bank_fld_in [NODES][NFIELDS];
   out_type  bank_fld_ff [NODES][NFIELDS];
   kind_type bank_kind_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         load_ff   <= 1'b0;
      end else begin
         s0_vld_ff <= issue.valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         load_ff   <= s5_vld_ff;
      end
   end

   // Stage 1 logic: linear terms, operand select by element kind
   always_comb begin
      r_w       = op_type'(s0_r_ff);
      s_w       = op_type'(s0_s_ff);
      lin_in.r  = r_w;
      lin_in.s  = s_w;
      lin_in.t  = ONE_OP - r_w - s_w;
      lin_in.rm = ONE_OP - r_w;
      lin_in.rp = ONE_OP + r_w;
      lin_in.sm = ONE_OP - s_w;
      lin_in.sp = ONE_OP + s_w;
      for (int i = 0; i < NMUL; i++) begin
         ma_in[i] = '0;
         mb_in[i] = '0;
      end
      if (s0_kind_ff == KIND_QUAD4 || s0_kind_ff == KIND_QUAD8) begin
         ma_in[0] = lin_in.rm;  mb_in[0] = lin_in.sm;
         ma_in[1] = lin_in.rp;  mb_in[1] = lin_in.sm;
         ma_in[2] = lin_in.rp;  mb_in[2] = lin_in.sp;
         ma_in[3] = lin_in.rm;  mb_in[3] = lin_in.sp;
         ma_in[4] = r_w;        mb_in[4] = r_w;
         ma_in[5] = s_w;        mb_in[5] = s_w;
         ma_in[6] = r_w;        mb_in[6] = lin_in.sm;
         ma_in[7] = r_w;        mb_in[7] = lin_in.sp;
         ma_in[8] = s_w;        mb_in[8] = lin_in.rp;
         ma_in[9] = s_w;        mb_in[9] = lin_in.rm;
      end else begin
         ma_in[0] = lin_in.t;   mb_in[0] = (lin_in.t <<< 1) - ONE_OP;
         ma_in[1] = r_w;        mb_in[1] = (r_w <<< 1) - ONE_OP;
         ma_in[2] = s_w;        mb_in[2] = (s_w <<< 1) - ONE_OP;
         ma_in[3] = lin_in.t;   mb_in[3] = r_w;
         ma_in[4] = r_w;        mb_in[4] = s_w;
         ma_in[5] = s_w;        mb_in[5] = lin_in.t;
      end
   end

   // Stage 3 logic: round products per element kind
   always_comb begin
      quad = (s2_kind_ff == KIND_QUAD4 || s2_kind_ff == KIND_QUAD8);
      for (int i = 0; i < 6; i++) begin
         nv_in[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         x_in[i] = '0;
      end
      ta   = round_prod(p_ff[4], FRAC_BITS);
      tb   = round_prod(p_ff[5], FRAC_BITS);
      a_in = '0;
      b_in = '0;
      if (quad) begin
         for (int i = 0; i < 4; i++) begin
            nv_in[i] = round_prod(p_ff[i], FRAC_BITS + 2);
         end
         a_in    = ONE_A - a_type'(ta[AW-1:0]);
         b_in    = ONE_A - a_type'(tb[AW-1:0]);
         x_in[0] = -round_prod(p_ff[6], FRAC_BITS);
         x_in[1] = -round_prod(p_ff[7], FRAC_BITS);
         x_in[2] = -round_prod(p_ff[8], FRAC_BITS);
         x_in[3] = -round_prod(p_ff[9], FRAC_BITS);
      end else begin
         // Quadratic vertex terms, then the 4x edge terms folded into the rounding
         for (int i = 0; i < 3; i++) begin
            nv_in[i] = round_prod(p_ff[i], FRAC_BITS);
         end
         for (int i = 3; i < 6; i++) begin
            nv_in[i] = round_prod(p_ff[i], FRAC_BITS - 2);
         end
      end
   end

   // Stage 5 logic: place every field of every node
   always_comb begin
      rv  = val_type'(lin4_ff.r);
      sv  = val_type'(lin4_ff.s);
      tv  = val_type'(lin4_ff.t);
      rmv = val_type'(lin4_ff.rm);
      rpv = val_type'(lin4_ff.rp);
      smv = val_type'(lin4_ff.sm);
      spv = val_type'(lin4_ff.sp);
      av  = val_type'(a4_ff);
      bv  = val_type'(b4_ff);
      for (int nd = 0; nd < NODES; nd++) begin
         for (int fd = 0; fd < NFIELDS; fd++) begin
            asm_in[nd][fd] = '0;
         end
      end
      unique case (s4_kind_ff)
         KIND_TRI3: begin
            asm_in[0][FLD_H] = tv;
            asm_in[1][FLD_H] = rv;
            asm_in[2][FLD_H] = sv;
            asm_in[0][FLD_R] = -ONE_V;
            asm_in[1][FLD_R] = ONE_V;
            asm_in[0][FLD_S] = -ONE_V;
            asm_in[2][FLD_S] = ONE_V;
         end
         KIND_TRI6: begin
            for (int nd = 0; nd < 6; nd++) begin
               asm_in[nd][FLD_H] = nv4_ff[nd];
            end
            asm_in[0][FLD_R]  = (rv <<< 2) + (sv <<< 2) - ONE_V - (ONE_V <<< 1);
            asm_in[1][FLD_R]  = (rv <<< 2) - ONE_V;
            asm_in[3][FLD_R]  = FOUR_V - (rv <<< 3) - (sv <<< 2);
            asm_in[4][FLD_R]  = sv <<< 2;
            asm_in[5][FLD_R]  = -(sv <<< 2);
            asm_in[0][FLD_S]  = (sv <<< 2) + (rv <<< 2) - ONE_V - (ONE_V <<< 1);
            asm_in[2][FLD_S]  = (sv <<< 2) - ONE_V;
            asm_in[3][FLD_S]  = -(rv <<< 2);
            asm_in[4][FLD_S]  = rv <<< 2;
            asm_in[5][FLD_S]  = FOUR_V - (sv <<< 3) - (rv <<< 2);
            asm_in[0][FLD_RR] = FOUR_V;
            asm_in[0][FLD_RS] = FOUR_V;
            asm_in[0][FLD_SS] = FOUR_V;
            asm_in[1][FLD_RR] = FOUR_V;
            asm_in[2][FLD_SS] = FOUR_V;
            asm_in[3][FLD_RR] = -EIGHT_V;
            asm_in[3][FLD_RS] = -FOUR_V;
            asm_in[4][FLD_RS] = FOUR_V;
            asm_in[5][FLD_RS] = -FOUR_V;
            asm_in[5][FLD_SS] = -EIGHT_V;
         end
         KIND_QUAD4, KIND_QUAD8: begin
            // Bilinear corner terms
            for (int nd = 0; nd < 4; nd++) begin
               asm_in[nd][FLD_H] = nv4_ff[nd];
            end
            asm_in[0][FLD_R]  = round_v(-smv, 2);
            asm_in[1][FLD_R]  = round_v(smv, 2);
            asm_in[2][FLD_R]  = round_v(spv, 2);
            asm_in[3][FLD_R]  = round_v(-spv, 2);
            asm_in[0][FLD_S]  = round_v(-rmv, 2);
            asm_in[1][FLD_S]  = round_v(-rpv, 2);
            asm_in[2][FLD_S]  = round_v(rpv, 2);
            asm_in[3][FLD_S]  = round_v(rmv, 2);
            asm_in[0][FLD_RS] = QUARTER_V;
            asm_in[1][FLD_RS] = -QUARTER_V;
            asm_in[2][FLD_RS] = QUARTER_V;
            asm_in[3][FLD_RS] = -QUARTER_V;
            // Serendipity edge nodes
            if (s4_kind_ff == KIND_QUAD8) begin
               asm_in[4][FLD_H]  = round_q(q_ff[0], FRAC_BITS + 1);
               asm_in[5][FLD_H]  = round_q(q_ff[1], FRAC_BITS + 1);
               asm_in[6][FLD_H]  = round_q(q_ff[2], FRAC_BITS + 1);
               asm_in[7][FLD_H]  = round_q(q_ff[3], FRAC_BITS + 1);
               asm_in[4][FLD_R]  = x4_ff[0];
               asm_in[5][FLD_R]  = round_v(bv, 1);
               asm_in[6][FLD_R]  = x4_ff[1];
               asm_in[7][FLD_R]  = round_v(-bv, 1);
               asm_in[4][FLD_S]  = round_v(-av, 1);
               asm_in[5][FLD_S]  = x4_ff[2];
               asm_in[6][FLD_S]  = round_v(av, 1);
               asm_in[7][FLD_S]  = x4_ff[3];
               asm_in[4][FLD_RR] = -smv;
               asm_in[6][FLD_RR] = -spv;
               asm_in[4][FLD_RS] = rv;
               asm_in[5][FLD_RS] = -sv;
               asm_in[6][FLD_RS] = -rv;
               asm_in[7][FLD_RS] = sv;
               asm_in[5][FLD_SS] = -rpv;
               asm_in[7][FLD_SS] = -rmv;
            end
         end
      endcase
   end

   // Stage 6 logic: subtract half of the two adjacent edge node values from each quad8 corner, then clamp
   always_comb begin
      for (int nd = 0; nd < NODES; nd++) begin
         for (int fd = 0; fd < NFIELDS; fd++) begin
            fix[nd][fd] = s5_fld_ff[nd][fd];
         end
      end
      if (s5_kind_ff == KIND_QUAD8) begin
         for (int fd = 0; fd < NFIELDS; fd++) begin
            fix[0][fd] = s5_fld_ff[0][fd] + round_v(-(s5_fld_ff[4][fd] + s5_fld_ff[7][fd]), 1);
            fix[1][fd] = s5_fld_ff[1][fd] + round_v(-(s5_fld_ff[4][fd] + s5_fld_ff[5][fd]), 1);
            fix[2][fd] = s5_fld_ff[2][fd] + round_v(-(s5_fld_ff[5][fd] + s5_fld_ff[6][fd]), 1);
            fix[3][fd] = s5_fld_ff[3][fd] + round_v(-(s5_fld_ff[6][fd] + s5_fld_ff[7][fd]), 1);
         end
      end
      for (int nd = 0; nd < NODES; nd++) begin
         for (int fd = 0; fd < NFIELDS; fd++) begin
            bank_fld_in[nd][fd] = sat_out(fix[nd][fd]);
         end
      end
   end

   // Stage payload registers
   always_ff @(posedge clock) begin
      s0_r_ff    <= issue.r;
      s0_s_ff    <= issue.s;
      s0_kind_ff <= issue.kind;

      lin1_ff    <= lin_in;
      s1_kind_ff <= s0_kind_ff;
      for (int i = 0; i < NMUL; i++) begin
         ma_ff[i] <= ma_in[i];
         mb_ff[i] <= mb_in[i];
      end

      for (int i = 0; i < NMUL; i++) begin
         p_ff[i] <= ma_ff[i] * mb_ff[i];
      end
      lin2_ff    <= lin1_ff;
      s2_kind_ff <= s1_kind_ff;

      for (int i = 0; i < 6; i++) begin
         nv_ff[i] <= nv_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         x_ff[i] <= x_in[i];
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      lin3_ff    <= lin2_ff;
      s3_kind_ff <= s2_kind_ff;

      q_ff[0]    <= a_ff * lin3_ff.sm;
      q_ff[1]    <= b_ff * lin3_ff.rp;
      q_ff[2]    <= a_ff * lin3_ff.sp;
      q_ff[3]    <= b_ff * lin3_ff.rm;
      for (int i = 0; i < 6; i++) begin
         nv4_ff[i] <= nv_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         x4_ff[i] <= x_ff[i];
      end
      a4_ff      <= a_ff;
      b4_ff      <= b_ff;
      lin4_ff    <= lin3_ff;
      s4_kind_ff <= s3_kind_ff;

      for (int nd = 0; nd < NODES; nd++) begin
         for (int fd = 0; fd < NFIELDS; fd++) begin
            s5_fld_ff[nd][fd] <= asm_in[nd][fd];
         end
      end
      s5_kind_ff <= s4_kind_ff;
   end

   // Hold the result bank until the next item lands
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_kind_ff <= KIND_TRI3;
      end else if (s5_vld_ff) begin
         bank_kind_ff <= s5_kind_ff;
         for (int nd = 0; nd < NODES; nd++) begin
            for (int fd = 0; fd < NFIELDS; fd++) begin
               bank_fld_ff[nd][fd] <= bank_fld_in[nd][fd];
            end
         end
      end
   end

   always_comb begin
      bank.load = load_ff;
      bank.kind = bank_kind_ff;
      for (int nd = 0; nd < NODES; nd++) begin
         for (int fd = 0; fd < NFIELDS; fd++) begin
            bank.fld[nd][fd] = bank_fld_ff[nd][fd];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/fem_2d_shape_function_eval_top.sv -----
// Top level of the 2D shape function evaluator: config register, issue throttle, result emitter.
// Depends on fsfe_pkg and fsfe_pipe.
`default_nettype none

// One (r,s) beat yields one result beat per element node, node 0 first, without gaps:
// 3 for tri3, 6 for tri6, 4 for quad4, 8 for quad8. Node 0 shows on the rsp_ ports once the
// start beat has passed the pipeline stages, the result bank and the rsp_ output registers,
// and rsp_last_node marks the final node. After each start beat, busy stays high until the
// gap counter, loaded with the last node index, has counted down to zero; a new coordinate
// may follow as soon as busy drops, while earlier results are still being sent.
// The receiver cannot stall; every result is on the ports for exactly one cycle with
// rsp_valid high. Change element_kind only while no results are outstanding.
module fem_2d_shape_function_eval_top
   import fsfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // coordinate input
   input  wire logic       start,
   output logic            busy,
   input  wire coord_type  req_r_coord,
   input  wire coord_type  req_s_coord,
   // result output
   output logic            rsp_valid,
   output node_type        rsp_node_index,
   output out_type         rsp_value,
   output out_type         rsp_d_r,
   output out_type         rsp_d_s,
   output out_type         rsp_d_rr,
   output out_type         rsp_d_rs,
   output out_type         rsp_d_ss,
   output logic            rsp_last_node,
   // element kind register
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_element_kind
);

   kind_type  kind_ff, kind_in;
   node_type  gap_ff, gap_in;
   logic      accept;
   issue_type issue;
   bank_type  bank;

   logic      emitting, emit_act_ff, emit_act_in;
   node_type  emit_idx_ff, emit_idx_in, sel, last_idx;

   logic      rsp_valid_ff, rsp_last_ff;
   node_type  rsp_node_ff;
   out_type   rsp_fld_ff [NFIELDS];

   // Element kind register
   assign csr_ready = 1'b1;

   always_comb begin
      kind_in = kind_ff;
      if (csr_valid && csr_ready) begin
         kind_in = kind_type'(csr_element_kind);
      end
   end

   // Throttle issue: busy blocks start until the gap counter, loaded with the last node index, reaches zero
   assign busy   = (gap_ff != '0);
   assign accept = start && !busy;

   always_comb begin
      priority if (accept) begin
         gap_in = last_index(kind_ff);
      end else if (busy) begin
         gap_in = gap_ff - 3'd1;
      end else begin
         gap_in = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_TRI3;
         gap_ff  <= '0;
      end else begin
         kind_ff <= kind_in;
         gap_ff  <= gap_in;
      end
   end

   always_comb begin
      issue.valid = accept;
      issue.r     = req_r_coord;
      issue.s     = req_s_coord;
      issue.kind  = kind_ff;
   end

   fsfe_pipe u_pipe (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .bank  (bank)
   );

   // Walk the bank, one node beat per cycle; a fresh load starts at node 0
   always_comb begin
      emitting    = bank.load || emit_act_ff;
      sel         = bank.load ? '0 : emit_idx_ff;
      last_idx    = last_index(bank.kind);
      emit_act_in = emitting && (sel != last_idx);
      emit_idx_in = emitting ? sel + 3'd1 : emit_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_act_ff  <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_act_ff  <= emit_act_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= emitting;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      if (emitting) begin
         rsp_node_ff <= sel;
         rsp_last_ff <= (sel == last_idx);
         for (int fd = 0; fd < NFIELDS; fd++) begin
            rsp_fld_ff[fd] <= bank.fld[sel][fd];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_index = rsp_node_ff;
   assign rsp_last_node  = rsp_last_ff;
   assign rsp_value      = rsp_fld_ff[FLD_H];
   assign rsp_d_r        = rsp_fld_ff[FLD_R];
   assign rsp_d_s        = rsp_fld_ff[FLD_S];
   assign rsp_d_rr       = rsp_fld_ff[FLD_RR];
   assign rsp_d_rs       = rsp_fld_ff[FLD_RS];
   assign rsp_d_ss       = rsp_fld_ff[FLD_SS];

   // An accepted beat must block the next cycle's start
   a_throttle: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("start accepted on back-to-back cycles");

   // A new bank must never land while the previous one is still being sent
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      bank.load |-> !emit_act_ff)
      else $error("result bank overwritten during emission");

   // Nodes of one item come out in order without gaps
   a_node_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_node |=>
         rsp_valid && (rsp_node_index == node_type'($past(rsp_node_index) + 3'd1)))
      else $error("node results out of sequence");

endmodule

`default_nettype wire
